@@ rtl/mmeut_pkg.sv @@
// Shared types and constants for the multi-motor encoder unwrap tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mmeut_pkg;

    // Field widths fixed by the frame and result formats
    localparam int ID_W       = 11;
    localparam int POS_W      = 13;
    localparam int STEP_W     = 14;
    localparam int TURN_W     = 16;
    localparam int ABS_W      = 29;
    localparam int ANGLE_W    = 30;
    localparam int MIDX_W     = 2;
    localparam int CNT_W      = 11;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // One encoder turn in counts
    localparam int POS_MOD = 8192;

    localparam logic [CNT_W-1:0]         CNT_MAX  = '1;
    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THR   = 2'd2;

    // Reset values
    localparam logic [ID_W-1:0]    BASE_ID_RST    = 11'd513;
    localparam logic [LIMIT_W-1:0] BIAS_LIMIT_RST = 10'd50;
    localparam logic [POS_W-1:0]   WRAP_THR_RST   = 13'd7500;

    typedef struct packed {
        logic [ID_W-1:0]    base_id;
        logic [LIMIT_W-1:0] bias_limit;
        logic [POS_W-1:0]   wrap_thr;
    } cfg_t;

endpackage

@@ rtl/mmeut_cfg_regs.sv @@
// Configuration register file: motor base ID, bias frame limit, wrap threshold.
// Depends on mmeut_pkg.
`timescale 1ns / 1ps

module mmeut_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mmeut_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmeut_pkg::CFG_DATA_W-1:0] cfg_data,
    output mmeut_pkg::cfg_t                  cfg
);
    import mmeut_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_id    <= BASE_ID_RST;
            cfg_reg.bias_limit <= BIAS_LIMIT_RST;
            cfg_reg.wrap_thr   <= WRAP_THR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_ID:    cfg_reg.base_id    <= cfg_data[ID_W-1:0];
                CFG_BIAS_LIMIT: cfg_reg.bias_limit <= cfg_data[LIMIT_W-1:0];
                CFG_WRAP_THR:   cfg_reg.wrap_thr   <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/mmeut_unwrap.sv @@
// Position step with turn-crossing correction and saturating turn count.
// Depends on mmeut_pkg.
`timescale 1ns / 1ps

module mmeut_unwrap (
    input  logic [mmeut_pkg::POS_W-1:0]         pos,
    input  logic [mmeut_pkg::POS_W-1:0]         prev,
    input  logic [mmeut_pkg::POS_W-1:0]         thr,
    input  logic signed [mmeut_pkg::TURN_W-1:0] turns_in,
    output logic signed [mmeut_pkg::STEP_W-1:0] step,
    output logic signed [mmeut_pkg::TURN_W-1:0] turns_out
);
    import mmeut_pkg::*;

    logic signed [STEP_W:0] diff;
    logic signed [STEP_W:0] thr_s;
    logic signed [STEP_W:0] mod_s;

    assign diff  = $signed((STEP_W+1)'(pos)) - $signed((STEP_W+1)'(prev));
    assign thr_s = $signed((STEP_W+1)'(thr));
    assign mod_s = $signed((STEP_W+1)'(POS_MOD));

    always_comb begin
        turns_out = turns_in;
        priority if (diff < -thr_s) begin
            // forward across the zero mark
            step = STEP_W'(diff + mod_s);
            if (turns_in != TURN_MAX) begin
                turns_out = turns_in + $signed(TURN_W'(1));
            end
        end else if (diff > thr_s) begin
            // backward across the zero mark
            step = STEP_W'(diff - mod_s);
            if (turns_in != TURN_MIN) begin
                turns_out = turns_in - $signed(TURN_W'(1));
            end
        end else begin
            step = STEP_W'(diff);
        end
    end

endmodule

@@ rtl/mmeut_avg_div.sv @@
// Ring-sum divide by the window length, truncated toward zero.
// Reciprocal multiply, two pipeline stages. Depends on mmeut_pkg.
`timescale 1ns / 1ps

module mmeut_avg_div #(
    parameter int SPEED_WINDOW = 8,
    parameter int SUM_W        = 17
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [SUM_W-1:0]             sum,
    output logic signed [mmeut_pkg::STEP_W-1:0] quot,
    output logic                                done
);
    import mmeut_pkg::*;

    // Exact for magnitudes below 2^SUM_W with K = SUM_W + ceil(log2 W)
    localparam int LOG_W  = $clog2(SPEED_WINDOW);
    localparam int DIV_K  = SUM_W + LOG_W;
    localparam int MUL_W  = DIV_K + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam longint unsigned DIV_M_L =
        ((64'd1 << DIV_K) + 64'(SPEED_WINDOW) - 64'd1) / 64'(SPEED_WINDOW);
    localparam logic [MUL_W-1:0] DIV_M = MUL_W'(DIV_M_L);

    logic [SUM_W-1:0]         mag;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic                     v1_reg;
    logic [STEP_W-1:0]        q_mag;
    logic signed [STEP_W-1:0] quot_reg;
    logic                     done_reg;

    assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign q_mag = prod_reg[DIV_K +: STEP_W];
    assign quot  = quot_reg;
    assign done  = done_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(DIV_M);
            neg_reg  <= sum[SUM_W-1];
        end
        if (v1_reg) begin
            quot_reg <= neg_reg ? $signed(-q_mag) : $signed(q_mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            if (start) begin
                done_reg <= 1'b0;
            end else if (v1_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/multi_motor_encoder_unwrap_tracker.sv @@
// Top level of the multi-motor encoder unwrap tracker: frame routing, per-motor
// state memory, speed ring memory and sequencer. Depends on mmeut_pkg,
// mmeut_cfg_regs, mmeut_unwrap and mmeut_avg_div.
//
//  channel | dir | handshake            | beat payload
//  --------+-----+----------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready    | frame_id, position_word
//  m_      | out | m_valid / m_ready    | motor_index, bias_captured, step_speed,
//          |     |                      | filtered_speed, turn_count,
//          |     |                      | absolute_position, angle_counts
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// Motor frame: state read at the beat, ring read, write-back, two divider stages,
// then the result loads; next beat the cycle after, so one motor frame at a time,
// other frames one per cycle while the sequencer is idle.
// Synchronous active-low reset clears control, the frame counter and per-motor
// valid bits; no memory sweep: invalid entries and unwrapped ring slots read as 0.
// A stalled m_ channel holds the sequencer in its divide step, s_ready low.
`timescale 1ns / 1ps

module multi_motor_encoder_unwrap_tracker #(
    parameter int SPEED_WINDOW = 8,
    parameter int MOTOR_COUNT  = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input frames
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mmeut_pkg::ID_W-1:0]           s_frame_id,
    input  logic [mmeut_pkg::POS_W-1:0]          s_position_word,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mmeut_pkg::MIDX_W-1:0]         m_motor_index,
    output logic                                 m_bias_captured,
    output logic signed [mmeut_pkg::STEP_W-1:0]  m_step_speed,
    output logic signed [mmeut_pkg::STEP_W-1:0]  m_filtered_speed,
    output logic signed [mmeut_pkg::TURN_W-1:0]  m_turn_count,
    output logic signed [mmeut_pkg::ABS_W-1:0]   m_absolute_position,
    output logic signed [mmeut_pkg::ANGLE_W-1:0] m_angle_counts,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmeut_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mmeut_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mmeut_pkg::*;

    localparam int MI_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int SLOT_W     = (SPEED_WINDOW > 1) ? $clog2(SPEED_WINDOW) : 1;
    localparam int SUM_W      = STEP_W + $clog2(SPEED_WINDOW);
    localparam int RING_DEPTH = MOTOR_COUNT * SPEED_WINDOW;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [ID_W-1:0]    MOTOR_CNT_ID = ID_W'(MOTOR_COUNT);
    localparam logic [SLOT_W-1:0]  SLOT_LAST    = SLOT_W'(SPEED_WINDOW - 1);
    localparam logic [RING_AW-1:0] WIN_A        = RING_AW'(SPEED_WINDOW);

    // sequencer
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STATE = 2'd1;
    localparam logic [1:0] S_RING  = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    // per-motor tracker entry
    typedef struct packed {
        logic [POS_W-1:0]         bias;
        logic [POS_W-1:0]         prev;
        logic signed [TURN_W-1:0] turns;
        logic [SLOT_W-1:0]        slot;
        logic                     wrapped;  // every ring slot written once
        logic signed [SUM_W-1:0]  sum;
    } entry_t;

    cfg_t cfg;

    logic [1:0]       fsm_reg;
    logic [1:0]       fsm_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // input decode
    logic            s_accept;
    logic [ID_W-1:0] id_off;
    logic            id_hit;
    logic [MI_W-1:0] m_in;
    logic            cap_in;

    // latched frame
    logic [MI_W-1:0]  m_reg;
    logic [POS_W-1:0] pos_reg;
    logic             cap_reg;

    // state memory
    entry_t                 st_mem [0:MOTOR_COUNT-1];
    entry_t                 st_rdata_reg;
    logic                   st_hit_reg;
    logic [MOTOR_COUNT-1:0] st_valid_reg;
    logic                   st_we;
    entry_t                 st_wdata;
    entry_t                 entry;

    // ring memory
    logic signed [STEP_W-1:0] ring_mem [0:RING_DEPTH-1];
    logic signed [STEP_W-1:0] ring_rdata_reg;
    logic [RING_AW-1:0]       ring_addr;
    logic [RING_AW-1:0]       ring_addr_reg;
    logic                     ring_re;
    logic                     ring_we;
    logic signed [STEP_W-1:0] ring_old;

    // tracking math
    logic signed [STEP_W-1:0] step_w;
    logic signed [TURN_W-1:0] turns_w;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [TURN_W-1:0] turns_new_reg;
    logic signed [SUM_W-1:0]  sum_new;
    logic [SLOT_W-1:0]        slot_inc;

    // divider
    logic                     div_start;
    logic signed [STEP_W-1:0] div_quot;
    logic                     div_done;

    // result
    logic                      out_free;
    logic                      out_load;
    logic signed [TURN_W-1:0]  t_final;
    logic signed [STEP_W-1:0]  pos_delta;
    logic signed [ANGLE_W-1:0] angle_w;
    logic [MI_W+1:0]           m_ext;

    logic                      m_valid_reg;
    logic [MIDX_W-1:0]         m_idx_reg;
    logic                      m_cap_reg;
    logic signed [STEP_W-1:0]  m_step_reg;
    logic signed [STEP_W-1:0]  m_filt_reg;
    logic signed [TURN_W-1:0]  m_turn_reg;
    logic signed [ABS_W-1:0]   m_abs_reg;
    logic signed [ANGLE_W-1:0] m_angle_reg;

    mmeut_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Input decode: counter bump and motor routing
    // ------------------------------------------------------------------
    assign s_ready  = (fsm_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
    assign id_off   = s_frame_id - cfg.base_id;
    assign id_hit   = (s_frame_id >= cfg.base_id) && (id_off < MOTOR_CNT_ID);
    assign m_in     = id_off[MI_W-1:0];
    assign cap_in   = (cnt_next <= CNT_W'(cfg.bias_limit));

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_reg   <= m_in;
            pos_reg <= s_position_word;
            cap_reg <= cap_in;
        end
    end

    // ------------------------------------------------------------------
    // State memory, read at the input beat, written back in S_RING.
    // One frame in flight, so read and write never touch the same entry
    // in overlapping cycles.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[m_reg] <= st_wdata;
        end
        if (s_accept && id_hit) begin
            st_rdata_reg <= st_mem[m_in];
            st_hit_reg   <= st_valid_reg[m_in];
        end
    end

    assign entry = st_hit_reg ? st_rdata_reg : '0;

    mmeut_unwrap u_unwrap (
        .pos       (pos_reg),
        .prev      (entry.prev),
        .thr       (cfg.wrap_thr),
        .turns_in  (entry.turns),
        .step      (step_w),
        .turns_out (turns_w)
    );

    // ------------------------------------------------------------------
    // Speed ring: slot address from the entry, read in S_STATE
    // ------------------------------------------------------------------
    assign ring_addr = RING_AW'(m_reg) * WIN_A + RING_AW'(entry.slot);
    assign ring_re   = (fsm_reg == S_STATE);
    assign ring_we   = (fsm_reg == S_RING) && !cap_reg;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_addr_reg] <= step_reg;
        end
        if (ring_re) begin
            ring_rdata_reg <= ring_mem[ring_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_re) begin
            ring_addr_reg <= ring_addr;
            step_reg      <= step_w;
            turns_new_reg <= turns_w;
        end
    end

    // a slot not yet written since reset reads as zero
    assign ring_old = entry.wrapped ? ring_rdata_reg : '0;
    assign sum_new  = entry.sum + SUM_W'(step_reg) - SUM_W'(ring_old);
    assign slot_inc = (entry.slot == SLOT_LAST) ? '0 : entry.slot + SLOT_W'(1);

    always_comb begin
        st_wdata      = entry;
        st_wdata.prev = pos_reg;
        if (cap_reg) begin
            st_wdata.bias = pos_reg;
        end else begin
            st_wdata.turns   = turns_new_reg;
            st_wdata.slot    = slot_inc;
            st_wdata.wrapped = entry.wrapped || (entry.slot == SLOT_LAST);
            st_wdata.sum     = sum_new;
        end
    end

    assign st_we     = (fsm_reg == S_RING);
    assign div_start = (fsm_reg == S_RING);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
        end else if (st_we) begin
            st_valid_reg[m_reg] <= 1'b1;
        end
    end

    mmeut_avg_div #(
        .SPEED_WINDOW (SPEED_WINDOW),
        .SUM_W        (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (cap_reg ? entry.sum : sum_new),
        .quot    (div_quot),
        .done    (div_done)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (fsm_reg == S_DIV) && div_done && out_free;

    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE:  if (s_accept && id_hit) fsm_next = S_STATE;
            S_STATE: fsm_next = S_RING;
            S_RING:  fsm_next = S_DIV;
            S_DIV:   if (out_load) fsm_next = S_IDLE;
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= S_IDLE;
            cnt_reg <= '0;
        end else begin
            fsm_reg <= fsm_next;
            if (s_accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly; entry, step and turns regs stay put until idle
    // ------------------------------------------------------------------
    assign t_final   = cap_reg ? entry.turns : turns_new_reg;
    assign pos_delta = $signed(STEP_W'(pos_reg)) - $signed(STEP_W'(entry.bias));
    assign angle_w   = cap_reg ? ANGLE_W'($signed({t_final, POS_W'(0)}))
                               : ANGLE_W'($signed({t_final, POS_W'(0)}))
                                 + ANGLE_W'(pos_delta);
    assign m_ext     = {2'b00, m_reg};

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_idx_reg   <= m_ext[MIDX_W-1:0];
            m_cap_reg   <= cap_reg;
            m_step_reg  <= cap_reg ? '0 : step_reg;
            m_filt_reg  <= cap_reg ? '0 : div_quot;
            m_turn_reg  <= t_final;
            // pos is 0..8191, so turns*8192 + pos is a plain concatenation
            m_abs_reg   <= $signed({t_final, pos_reg});
            m_angle_reg <= angle_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_motor_index       = m_idx_reg;
    assign m_bias_captured     = m_cap_reg;
    assign m_step_speed        = m_step_reg;
    assign m_filtered_speed    = m_filt_reg;
    assign m_turn_count        = m_turn_reg;
    assign m_absolute_position = m_abs_reg;
    assign m_angle_counts      = m_angle_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cnt_reg >= $past(cnt_reg)))
        else $error("frame counter went backward");

    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> ##1 div_done)
        else $error("divider result not ready two cycles after start");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && (st_we || ring_re)))
        else $error("input beat taken while an entry is in flight");

    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (fsm_reg == S_IDLE) && m_valid_reg)
        else $error("result load did not free the sequencer");

    a_ring_after_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_re |=> st_we)
        else $error("ring read not followed by write-back");

endmodule

@@ tb/multi_motor_encoder_unwrap_tracker_tb.sv @@
// Self-checking testbench for multi_motor_encoder_unwrap_tracker: CAN frame beats in,
// per-motor unwrap/turn/speed results out, checked against an in-bench tracker model.
// Depends on mmeut_pkg and the RTL top level; reads no files.
`timescale 1ns / 1ps

module multi_motor_encoder_unwrap_tracker_tb;

    import mmeut_pkg::*;

    localparam int WINDOW        = 8;
    localparam int MOTORS        = 4;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 100_000;  // ~450 frames in all
    localparam int TURN_HI       = 32767;
    localparam int TURN_LO       = -32768;
    // index past the register list, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
    } can_frame_t;

    typedef struct {
        logic [MIDX_W-1:0]          motor;
        logic                       bias;
        logic signed [STEP_W-1:0]   step;
        logic signed [STEP_W-1:0]   filt;
        logic signed [TURN_W-1:0]   turns;
        logic signed [ABS_W-1:0]    abs_pos;
        logic signed [ANGLE_W-1:0]  angle;
    } tracker_update_t;

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [ID_W-1:0]             s_frame_id      = '0;
    logic [POS_W-1:0]            s_position_word = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [MIDX_W-1:0]           m_motor_index;
    logic                        m_bias_captured;
    logic signed [STEP_W-1:0]    m_step_speed;
    logic signed [STEP_W-1:0]    m_filtered_speed;
    logic signed [TURN_W-1:0]    m_turn_count;
    logic signed [ABS_W-1:0]     m_absolute_position;
    logic signed [ANGLE_W-1:0]   m_angle_counts;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;

    multi_motor_encoder_unwrap_tracker #(
        .SPEED_WINDOW (WINDOW),
        .MOTOR_COUNT  (MOTORS)
    ) uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_frame_id          (s_frame_id),
        .s_position_word     (s_position_word),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_motor_index       (m_motor_index),
        .m_bias_captured     (m_bias_captured),
        .m_step_speed        (m_step_speed),
        .m_filtered_speed    (m_filtered_speed),
        .m_turn_count        (m_turn_count),
        .m_absolute_position (m_absolute_position),
        .m_angle_counts      (m_angle_counts),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // ------------------------------------------------------------------
    // Tracker model state (mirrors the block's registers and memories)
    // ------------------------------------------------------------------
    cfg_t             live_cfg = '{BASE_ID_RST, BIAS_LIMIT_RST, WRAP_THR_RST};
    logic [CNT_W-1:0] frames_seen = '0;
    int               bias_pos   [MOTORS];
    int               prev_pos   [MOTORS];
    int               turns      [MOTORS];
    int               speed_sum  [MOTORS];
    int               ring_slot  [MOTORS];
    int               speed_ring [MOTORS][WINDOW];

    can_frame_t       frames_to_send[$];
    tracker_update_t  tracker_updates[$];
    int               frames_queued  = 0;  // frames queued so far == counter after they land
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               send_idle_pct  = 0;
    int               recv_idle_pct  = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Frame counter saturates; only motor frames in the id window produce an update.
    // Bias frames re-seed bias and previous position and leave the speed ring alone.
    function automatic void advance_trackers(input logic [ID_W-1:0] id,
                                             input logic [POS_W-1:0] pos);
        int              m;
        int              diff;
        int              thr;
        int              step;
        int              filt;
        int              t;
        int              abs_v;
        int              ang_v;
        bit              capture;
        tracker_update_t u;
        if (frames_seen < CNT_MAX)
            frames_seen++;
        if (int'(id) < int'(live_cfg.base_id) || int'(id) - int'(live_cfg.base_id) >= MOTORS)
            return;
        m       = int'(id) - int'(live_cfg.base_id);
        capture = frames_seen <= {1'b0, live_cfg.bias_limit};
        step    = 0;
        filt    = 0;
        if (capture) begin
            bias_pos[m] = int'(pos);
            prev_pos[m] = int'(pos);
        end else begin
            diff        = int'(pos) - prev_pos[m];
            thr         = int'(live_cfg.wrap_thr);
            prev_pos[m] = int'(pos);
            if (diff < -thr) begin
                if (turns[m] < TURN_HI) turns[m]++;
                step = diff + POS_MOD;
            end else if (diff > thr) begin
                if (turns[m] > TURN_LO) turns[m]--;
                step = diff - POS_MOD;
            end else begin
                step = diff;
            end
            speed_sum[m] += step - speed_ring[m][ring_slot[m]];
            speed_ring[m][ring_slot[m]] = step;
            ring_slot[m] = (ring_slot[m] + 1) % WINDOW;
            filt = speed_sum[m] / WINDOW;   // truncates toward zero
        end
        t     = turns[m];
        abs_v = int'(pos) + t * POS_MOD;
        ang_v = capture ? t * POS_MOD : int'(pos) - bias_pos[m] + t * POS_MOD;
        u.motor   = m[MIDX_W-1:0];
        u.bias    = capture;
        u.step    = step[STEP_W-1:0];
        u.filt    = filt[STEP_W-1:0];
        u.turns   = t[TURN_W-1:0];
        u.abs_pos = abs_v[ABS_W-1:0];
        u.angle   = ang_v[ANGLE_W-1:0];
        tracker_updates.push_back(u);
    endfunction

    task automatic note_mismatch(input string field, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, want %0d", $time, field, got, want);
    endtask

    function automatic bit is_motor_id(input logic [ID_W-1:0] id);
        return int'(id) >= int'(live_cfg.base_id) &&
               int'(id) - int'(live_cfg.base_id) < MOTORS;
    endfunction

    function automatic logic [ID_W-1:0] foreign_id();
        logic [ID_W-1:0] id;
        do id = ID_W'($urandom_range(2047)); while (is_motor_id(id));
        return id;
    endfunction

    // ------------------------------------------------------------------
    // Frame driver: takes the next pending frame once the current beat is gone
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid         <= 1'b1;
                s_frame_id      <= frames_to_send[0].id;
                s_position_word <= frames_to_send[0].pos;
                void'(frames_to_send.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result beats, then predict from accepted frame beats.
    // A result can never belong to a frame accepted on the same edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tracker_update_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tracker_updates.size() == 0) begin
                    note_mismatch("result beat with nothing expected", m_motor_index, -1);
                end else begin
                    want = tracker_updates.pop_front();
                    if (m_motor_index !== want.motor)
                        note_mismatch("motor_index", m_motor_index, want.motor);
                    if (m_bias_captured !== want.bias)
                        note_mismatch("bias_captured", m_bias_captured, want.bias);
                    if (m_step_speed !== want.step)
                        note_mismatch("step_speed", m_step_speed, want.step);
                    if (m_filtered_speed !== want.filt)
                        note_mismatch("filtered_speed", m_filtered_speed, want.filt);
                    if (m_turn_count !== want.turns)
                        note_mismatch("turn_count", m_turn_count, want.turns);
                    if (m_absolute_position !== want.abs_pos)
                        note_mismatch("absolute_position", m_absolute_position, want.abs_pos);
                    if (m_angle_counts !== want.angle)
                        note_mismatch("angle_counts", m_angle_counts, want.angle);
                end
            end
            if (s_valid && s_ready)
                advance_trackers(s_frame_id, s_position_word);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(input logic [ID_W-1:0] id, input logic [POS_W-1:0] pos);
        can_frame_t f;
        f.id  = id;
        f.pos = pos;
        frames_to_send.push_back(f);
        frames_queued++;
    endtask

    // non-motor frames only move the frame counter
    task automatic pad_to(input int count);
        while (frames_queued < count)
            send(foreign_id(), POS_W'($urandom_range(8191)));
    endtask

    // Mostly motor frames, positions biased toward both ends of the turn so that
    // successive frames cross the wrap point often; ~20% foreign ids as noise.
    task automatic queue_random(input int n);
        int               sel;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 40)
                pos = POS_W'($urandom_range(8191));
            else if (sel < 90)
                pos = $urandom_range(1) ? POS_W'($urandom_range(150))
                                        : POS_W'(8191 - $urandom_range(150));
            else
                pos = $urandom_range(1) ? POS_W'(0) : POS_W'(8191);
            if ($urandom_range(99) < 20)
                id = foreign_id();
            else
                id = live_cfg.base_id + ID_W'($urandom_range(MOTORS - 1));
            send(id, pos);
        end
    endtask

    // Block must be idle before a register write; foreign frames give no result,
    // so wait out SETTLE_CYCLES after the last update.
    task automatic drain();
        while (frames_to_send.size() != 0 || s_valid || tracker_updates.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_ID:    live_cfg.base_id    = data[ID_W-1:0];
            CFG_BIAS_LIMIT: live_cfg.bias_limit = data[LIMIT_W-1:0];
            CFG_WRAP_THR:   live_cfg.wrap_thr   = data[POS_W-1:0];
            default:        ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase 0: reset settings (base 513, bias limit 50, threshold 7500)
        send_idle_pct = 16;
        recv_idle_pct = 66;
        send(11'd513, 13'd0);       // bias captures, both position extremes
        send(11'd516, 13'd8191);
        send(11'd0,    13'd8191);   // foreign ids: extremes and both window edges
        send(11'd2047, 13'd0);
        send(11'd512,  13'd100);
        send(11'd517,  13'd100);
        send(11'd514, 13'd4000);
        send(11'd515, 13'd8191);
        pad_to(48);
        send(11'd513, 13'd10);      // frame 49: capture
        send(11'd513, 13'd8000);    // frame 50: counter == limit, still capture
        send(11'd513, 13'd100);     // first tracked frame: wrap forward off the bias
        send(11'd513, 13'd8100);    // wrap backward
        send(11'd513, 13'd600);     // step exactly -threshold: no wrap
        send(11'd513, 13'd8100);    // step exactly +threshold: no wrap
        send(11'd513, 13'd599);     // one past -threshold: wrap
        send(11'd514, 13'd0);       // plain negative step
        send(11'd516, 13'd0);       // full-scale jump, wraps
        send(11'd515, 13'd0);
        queue_random(110);
        drain();

        // Phase 1: base 0, bias window reaching past the counter, unmapped index ignored
        write_reg(CFG_BASE_ID,    13'h0000);
        write_reg(CFG_BIAS_LIMIT, 13'h1CFA);   // upper bits dropped -> 250
        write_reg(CFG_WRAP_THR,   13'd2000);
        write_reg(CFG_UNMAPPED,   13'h1555);
        queue_random(60);
        pad_to(249);
        send(11'd1, 13'd123);       // frame 250: last capture
        send(11'd1, 13'd8000);      // frame 251: tracked, wraps backward
        drain();

        // Phase 2: top of id range, no bias window, threshold at max (never wraps)
        send_idle_pct = 66;
        recv_idle_pct = 16;
        write_reg(CFG_BASE_ID,    13'h1FFC);   // -> 2044
        write_reg(CFG_BIAS_LIMIT, 13'h1C00);   // -> 0
        write_reg(CFG_WRAP_THR,   13'h1FFF);
        queue_random(80);
        drain();

        // Phase 3: mid settings, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BASE_ID,    13'd1000);
        write_reg(CFG_BIAS_LIMIT, 13'd50);
        write_reg(CFG_WRAP_THR,   13'd4096);
        queue_random(80);
        drain();

        // Phase 4: threshold 0 turns every nonzero step into a turn; motor 0 walks
        // down, motor 1 walks up. The first few frames still fall in the bias window.
        write_reg(CFG_BASE_ID,    13'd513);
        write_reg(CFG_BIAS_LIMIT, 13'd415);
        write_reg(CFG_WRAP_THR,   13'd0);
        for (int k = 0; k < 20; k++)
            send(11'd513, POS_W'(8191 - k * 37));
        for (int k = 0; k < 20; k++)
            send(11'd514, POS_W'(k * 37));
        drain();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
